// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Each expands to one labeled concurrent assertion clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while rst_n is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, including during reset.
`define ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/asfo_pkg.sv =====
// Package for the silence trim / fade-out unit: register map, reset values,
// and the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package asfo_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int CNT_W = 24;
  localparam int POS_W = 25;

  localparam logic [CFG_IDX_W-1:0] CFG_SONG_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_EN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_MAX = 3'd4;

  localparam logic [CNT_W-1:0] SONG_LEN_RST = 24'd4086460;
  localparam logic [CNT_W-1:0] FADE_LEN_RST = 24'd240380;
  localparam logic [CNT_W-1:0] SKIP_MAX_RST = 24'd120190;

  typedef enum logic [1:0] {
    OSEL_ZERO,
    OSEL_PASS,
    OSEL_SCALED
  } out_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     sil_inc;
    logic     pos_inc;
    logic     gain_load;
    logic     mul_start;
    logic     div_step;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic silent;
    logic sil_ge;
    logic sil_next_ge;
    logic fade_en;
    logic suppress;
    logic pos_ge_end;
    logic in_fade;
    logic pos_is_last;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/asfo_dp.sv =====
// Datapath: config registers, silence and frame counters, two-lane gain
// multiply and restoring divide, output register. Depends on asfo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asfo_dp #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [asfo_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [asfo_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire asfo_pkg::ctrl_cmd_t                   cmd,
  output asfo_pkg::dp_status_t                       st,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         out_tdata,
  output logic                                       out_tlast
);
  import asfo_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int DW = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int PW = SAMPLE_BITS + CNT_W;
  localparam int CW = $clog2(SAMPLE_BITS);

  logic [CNT_W-1:0] song_r, fade_r, skip_r;
  logic             fade_en_r, suppress_r;
  logic [CNT_W-1:0] sil_r;
  logic [POS_W-1:0] pos_r;

  logic [S-1:0]     smp_r [2];
  logic [CNT_W-1:0] g_r;
  logic [CNT_W-1:0] rem_r [2];
  logic [S-1:0]     lo_r  [2];
  logic [CW-1:0]    cnt_r;
  logic [S-1:0]     out_l_r, out_r_r;
  logic             out_last_r;

  logic [CNT_W-1:0] sil_sat;
  logic [POS_W-1:0] end_w;
  logic [POS_W-1:0] g_w;
  logic [S-1:0]     mag    [2];
  logic [PW-1:0]    prod   [2];
  logic [CNT_W:0]   trial  [2];
  logic [CNT_W:0]   diff   [2];
  logic             ge     [2];
  logic [S-1:0]     scaled [2];

  always_comb begin
    sil_sat = (sil_r == '1) ? sil_r : sil_r + 1'b1;
    end_w   = {1'b0, song_r} + {1'b0, fade_r};
    g_w     = end_w - pos_r;
    for (int i = 0; i < 2; i++) begin
      mag[i]    = smp_r[i][S-1] ? (~smp_r[i] + S'(1)) : smp_r[i];
      prod[i]   = PW'(mag[i]) * PW'(g_r);
      trial[i]  = {rem_r[i], lo_r[i][S-1]};
      diff[i]   = trial[i] - {1'b0, fade_r};
      ge[i]     = (trial[i] >= {1'b0, fade_r});
      scaled[i] = smp_r[i][S-1] ? (~lo_r[i] + S'(1)) : lo_r[i];
    end
  end

  assign st.silent      = (smp_r[0] == '0) && (smp_r[1] == '0);
  assign st.sil_ge      = (sil_r >= skip_r);
  assign st.sil_next_ge = (sil_sat >= skip_r);
  assign st.fade_en     = fade_en_r;
  assign st.suppress    = suppress_r;
  assign st.pos_ge_end  = (pos_r >= end_w);
  assign st.in_fade     = (pos_r > {1'b0, song_r}) && (fade_r != '0);
  assign st.pos_is_last = (pos_r == end_w - 1'b1);
  assign st.div_last    = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      song_r     <= SONG_LEN_RST;
      fade_r     <= FADE_LEN_RST;
      skip_r     <= SKIP_MAX_RST;
      fade_en_r  <= 1'b1;
      suppress_r <= 1'b1;
      sil_r      <= '0;
      pos_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SONG_LEN: song_r     <= cfg_data;
          CFG_FADE_LEN: fade_r     <= cfg_data;
          CFG_FADE_EN:  fade_en_r  <= cfg_data[0];
          CFG_SUPPRESS: suppress_r <= cfg_data[0];
          CFG_SKIP_MAX: skip_r     <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.sil_inc) sil_r <= sil_sat;
      if (cmd.pos_inc) pos_r <= pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      smp_r[0] <= in_tdata[S-1:0];
      smp_r[1] <= in_tdata[2*S-1:S];
    end
    // gain is at most fade length inside the ramp
    if (cmd.gain_load) g_r <= g_w[CNT_W-1:0];
    if (cmd.mul_start) begin
      for (int i = 0; i < 2; i++) begin
        rem_r[i] <= prod[i][PW-1:S];
        lo_r[i]  <= prod[i][S-1:0];
      end
      cnt_r <= CW'(S - 1);
    end else if (cmd.div_step) begin
      for (int i = 0; i < 2; i++) begin
        rem_r[i] <= ge[i] ? diff[i][CNT_W-1:0] : trial[i][CNT_W-1:0];
        lo_r[i]  <= {lo_r[i][S-2:0], ge[i]};
      end
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.out_load) begin
      out_last_r <= cmd.out_last;
      case (cmd.out_sel)
        OSEL_PASS: begin
          out_l_r <= smp_r[0];
          out_r_r <= smp_r[1];
        end
        OSEL_SCALED: begin
          out_l_r <= scaled[0];
          out_r_r <= scaled[1];
        end
        default: begin
          out_l_r <= '0;
          out_r_r <= '0;
        end
      endcase
    end
  end

  assign out_tdata = DW'({out_r_r, out_l_r});
  assign out_tlast = out_last_r;

endmodule

`default_nettype wire

// ===== src/asfo_ctrl.sv =====
// Controller: sequencing of one frame at a time, playback phase and
// output-valid tracking. Depends on asfo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asfo_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  input  wire asfo_pkg::dp_status_t st,
  output asfo_pkg::ctrl_cmd_t       cmd
);
  import asfo_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_DIV,
    ST_PUSH
  } state_t;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_PLAY,
    PH_DONE
  } phase_t;

  state_t   state_r, state_nxt;
  phase_t   phase_r, phase_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     last_r, last_nxt;
  out_sel_t sel_r, sel_nxt;
  logic     play;

  always_comb begin
    cmd           = '0;
    cmd.out_sel   = sel_r;
    cmd.out_last  = last_r;
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    last_nxt      = last_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_tready;
    play          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt = ST_IDLE;
        if (phase_r == PH_SKIP && st.suppress) begin
          if (st.sil_ge || (st.silent && st.sil_next_ge)) begin
            // silence timeout: zero frame marked last
            cmd.sil_inc = st.silent && !st.sil_ge;
            phase_nxt   = PH_DONE;
            sel_nxt     = OSEL_ZERO;
            last_nxt    = 1'b1;
            state_nxt   = ST_PUSH;
          end else if (st.silent) begin
            cmd.sil_inc = 1'b1;
          end else begin
            play = 1'b1;
          end
        end else if (phase_r == PH_SKIP || phase_r == PH_PLAY) begin
          play = 1'b1;
        end
        if (play) begin
          cmd.pos_inc = 1'b1;
          phase_nxt   = PH_PLAY;
          sel_nxt     = OSEL_PASS;
          last_nxt    = 1'b0;
          state_nxt   = ST_PUSH;
          if (st.fade_en) begin
            if (st.pos_ge_end) begin
              phase_nxt = PH_DONE;
              state_nxt = ST_IDLE;
            end else begin
              if (st.pos_is_last) begin
                last_nxt  = 1'b1;
                phase_nxt = PH_DONE;
              end
              if (st.in_fade) begin
                cmd.gain_load = 1'b1;
                sel_nxt       = OSEL_SCALED;
                state_nxt     = ST_MUL;
              end
            end
          end
        end
      end
      ST_MUL: begin
        cmd.mul_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_SKIP;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
      sel_r       <= OSEL_ZERO;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      sel_r       <= sel_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ===== src/audio_silence_skip_fade_out_unit.sv =====
// Leading-silence trim and linear fade-out for a stereo stream.
// Frames at full gain pass straight to the output register; frames in the fade are first
// scaled by a gain multiply and a restoring divide, where the restoring divider lanes
// retire one quotient bit per cycle. Dropped frames never reach the output.
// A finished frame waits in the output register while the next frame is taken in.
// Reset: synchronous, active low; state and config return to defaults, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module audio_silence_skip_fade_out_unit #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // in_left, in_right, zero pad
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // out_left, out_right, zero pad
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      out_tdata,
  output logic                                    out_tlast,
  input  wire logic                               cfg_wr_en,
  input  wire logic [asfo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [asfo_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import asfo_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  asfo_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  asfo_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

`default_nettype wire

// ===== src/asfo_check.sv =====
// Port-level checker for the silence trim / fade-out unit, bound to the top.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module asfo_check #(
  parameter int SAMPLE_BITS = 16
) (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] out_tdata,
  input wire logic                               out_tlast
);

  `ASSERT_ANY(a_rst_out_idle, !rst_n |=> !out_tvalid, "out_tvalid high after reset")
  `ASSERT_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output changed")
  `ASSERT_CLK(a_one_at_a_time, in_tvalid && in_tready |=> !in_tready, "input taken while frame in work")
  `ASSERT_CLK(a_end_quiet, out_tvalid && out_tready && out_tlast |=> !out_tvalid, "output after last frame")

endmodule

bind audio_silence_skip_fade_out_unit asfo_check #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_asfo_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
